FILE: hdl/mvm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvm_pkg
// Shared sizes and the pipeline tag of the matrix-vector multiply stream.
// ---------------------------------------------------------------------------
package mvm_pkg;

	localparam int VECTOR_DEPTH = 1024;
	localparam int OPERAND_BITS = 16;

	localparam int VALUE_W = 16;
	localparam int CFG_W   = 11;
	localparam int SUM_W   = 48;
	localparam int ROW_W   = 16;
	localparam int PROD_W  = 2 * OPERAND_BITS;
	localparam int OUT_W   = SUM_W + ROW_W;

	localparam int IDX_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int CNT_W = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;

	localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = CFG_W'(1024);

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_MATRIX = 1'b1;

	typedef struct packed {
		logic             valid;
		logic             load;
		logic             last;
		logic [ROW_W-1:0] row;
	} mvm_tag_t;

endpackage

FILE: hdl/mvm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module mvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/mvm_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvm_seq
// Column-count register, load and column positions, row counter and the
// vector store access for each accepted beat.
// ---------------------------------------------------------------------------
module mvm_seq import mvm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    accept,
	input  logic                    func,
	input  logic [OPERAND_BITS-1:0] operand,
	output logic                    ram_we,
	output logic                    ram_re,
	output logic [IDX_W-1:0]        ram_waddr,
	output logic [IDX_W-1:0]        ram_raddr,
	output logic [OPERAND_BITS-1:0] ram_wdata,
	output mvm_tag_t                tag_s1,
	output logic [OPERAND_BITS-1:0] a_s1
);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(VECTOR_DEPTH);

	logic [CFG_W-1:0] column_count_q;
	logic [IDX_W-1:0] load_pos_q;
	logic [IDX_W-1:0] col_pos_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] cnt_ext;
	logic [CNT_W-1:0] cols;
	logic [CNT_W-1:0] load_next;
	logic [CNT_W-1:0] col_next;
	logic             is_load;
	logic             row_end;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COLUMN_COUNT_RESET;
		end else if (cfg_valid) begin
			column_count_q <= cfg_data;
		end
	end

	always_comb begin
		cnt_ext = CNT_W'(column_count_q);
		if (column_count_q == '0) begin
			cols = CNT_W'(1);
		end else if (cnt_ext > DEPTH_CNT) begin
			cols = DEPTH_CNT;
		end else begin
			cols = cnt_ext;
		end
		load_next = CNT_W'(load_pos_q) + CNT_W'(1);
		col_next  = CNT_W'(col_pos_q) + CNT_W'(1);
		row_end   = (col_next >= cols);
	end

	assign is_load   = (func == FUNC_LOAD);
	assign ram_we    = accept && is_load;
	assign ram_re    = accept && !is_load;
	assign ram_waddr = load_pos_q;
	assign ram_raddr = col_pos_q;
	assign ram_wdata = operand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			col_pos_q  <= '0;
			row_q      <= '0;
			tag_s1     <= '0;
		end else if (en) begin
			tag_s1.valid <= accept;
			if (accept) begin
				tag_s1.load <= is_load;
				tag_s1.last <= row_end;
				tag_s1.row  <= row_q;
				if (is_load) begin
					load_pos_q <= (load_next >= cols) ? '0 : load_next[IDX_W-1:0];
					col_pos_q  <= '0;
					row_q      <= '0;
				end else if (row_end) begin
					col_pos_q <= '0;
					row_q     <= row_q + ROW_W'(1);
				end else begin
					col_pos_q <= col_next[IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && accept) begin
			a_s1 <= operand;
		end
	end

endmodule

FILE: hdl/mvm_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvm_mac
// Product stage, running-sum accumulator and the result register.
// ---------------------------------------------------------------------------
module mvm_mac import mvm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mvm_tag_t                tag_s1,
	input  logic [OPERAND_BITS-1:0] a_s1,
	input  logic [OPERAND_BITS-1:0] b_s1,
	output logic                    en,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_W-1:0]        m_tdata
);

	mvm_tag_t                  tag_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic        [SUM_W-1:0]   sum_q;
	logic        [SUM_W-1:0]   sum_next;
	logic        [SUM_W-1:0]   out_sum_q;
	logic        [ROW_W-1:0]   out_row_q;
	logic                      out_valid_q;
	logic                      emit;

	assign emit     = tag_s2.valid && !tag_s2.load && tag_s2.last;
	assign en       = !(out_valid_q && !m_tready && emit);
	assign sum_next = sum_q + SUM_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= $signed(a_s1) * $signed(b_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (en && tag_s2.valid) begin
				if (tag_s2.load || tag_s2.last) begin
					sum_q <= '0;
				end else begin
					sum_q <= sum_next;
				end
				if (emit) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && emit) begin
			out_sum_q <= sum_next;
			out_row_q <= tag_s2.row;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_row_q, out_sum_q};

endmodule

FILE: hdl/matrix_vector_multiply_stream.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_vector_multiply_stream
// The beat closing a row passes through the s1, s2 and result registers.
// Throughput: one beat per cycle; the input stalls only while a finished
// row waits on m_tready and the next row result reaches the accumulator.
// Reset: asynchronous, clears positions, row counter, sum and column count
// (1024); the vector store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module matrix_vector_multiply_stream import mvm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [VALUE_W-1:0]  s_tdata,   // value[15:0]
	input  logic                s_tuser,   // func
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,   // row_sum[47:0], row_index[63:48]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data   // column_count
);

	logic                    en;
	logic                    accept;
	logic                    ram_we;
	logic                    ram_re;
	logic [IDX_W-1:0]        ram_waddr;
	logic [IDX_W-1:0]        ram_raddr;
	logic [OPERAND_BITS-1:0] ram_wdata;
	logic [OPERAND_BITS-1:0] ram_rdata;
	mvm_tag_t                tag_s1;
	logic [OPERAND_BITS-1:0] a_s1;

	assign s_tready = en;
	assign accept   = s_tvalid && en;

	mvm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.func      (s_tuser),
		.operand   (s_tdata[OPERAND_BITS-1:0]),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr),
		.ram_wdata (ram_wdata),
		.tag_s1    (tag_s1),
		.a_s1      (a_s1)
	);

	mvm_ram #(
		.WIDTH (OPERAND_BITS),
		.DEPTH (VECTOR_DEPTH),
		.AW    (IDX_W)
	) u_vector_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mvm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1),
		.a_s1     (a_s1),
		.b_s1     (ram_rdata),
		.en       (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
